// ===== hdl/msc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the multichannel spectrum combiner
// Widths, register and mode codes, sequencer states, and the quarter-wave
// sine table that feeds the bus B phase rotation.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int FFT_LENGTH   = 1024;
  localparam int PHASE_BITS   = 10;
  localparam int MAX_CHANNELS = 4;

  localparam int SMP_W  = 16;
  localparam int BIN_W  = 10;
  localparam int CH_W   = 2;
  localparam int CNT_W  = 3;
  localparam int MODE_W = 2;
  localparam int CFG_W  = 16;
  localparam int SUM_W  = 18;
  localparam int POW_W  = 34;
  localparam int PROD_W = SUM_W + SMP_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int OUT_W  = 19;

  // root unit: two radicand bits per step
  localparam int ROOT_STEPS = POW_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int RSH_W      = REM_W + 2;
  localparam int RCNT_W     = $clog2(ROOT_STEPS);

  // phase index = round(|offset*bin| * 2^PHASE_BITS / (256*FFT_LENGTH))
  localparam int IDX_SHIFT = $clog2(256 * FFT_LENGTH) - PHASE_BITS;
  localparam int QB        = PHASE_BITS - 2;
  localparam int QTAB_SIZE = 1 << QB;

  localparam logic [MODE_W-1:0] MODE_POWER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPLIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELAY = 2'd2;

  typedef enum logic [CH_W-1:0] {
    REG_MODE   = 2'd0,
    REG_SPLIT  = 2'd1,
    REG_OFFSET = 2'd2,
    REG_COUNT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_PHASE,
    ST_INDEX,
    ST_LOOKUP,
    ST_ROT0,
    ST_ROT1,
    ST_ROT2,
    ST_ROT3,
    ST_ROUND,
    ST_ROOT,
    ST_ROOT_FIX,
    ST_RESULT
  } state_t;

  localparam logic [63:0] COEF1 = 64'd1686629713;
  localparam logic [63:0] COEF3 = 64'd693598668;
  localparam logic [63:0] COEF5 = 64'd85569306;
  localparam logic [63:0] COEF7 = 64'd5026995;
  localparam logic [63:0] COEF9 = 64'd172272;

  typedef logic [QTAB_SIZE-1:0][SMP_W-1:0] qsin_tab_t;

  // sin(pi*t/2), t in Q30, odd series, Q15 rounded half up and saturated
  function automatic logic [SMP_W-1:0] quarter_sine(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    t2 = (t * t) >> 30;
    p  = COEF7 - ((t2 * COEF9) >> 30);
    p  = COEF5 - ((t2 * p) >> 30);
    p  = COEF3 - ((t2 * p) >> 30);
    p  = COEF1 - ((t2 * p) >> 30);
    p  = (t * p) >> 30;
    p  = (p + 64'd16384) >> 15;
    if (p > 64'd32767) begin
      p = 64'd32767;
    end
    return p[SMP_W-1:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int j = 0; j < QTAB_SIZE; j++) begin
      tab[j] = quarter_sine(64'(j) << (30 - QB));
    end
    return tab;
  endfunction

  localparam qsin_tab_t        QSIN_TAB = build_qsin();
  localparam logic [SMP_W-1:0] QSIN_ONE = quarter_sine(64'd1 << 30);

endpackage
`default_nettype wire

// ===== hdl/multichannel_spectrum_combiner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_spectrum_combiner: per-bin combining of multichannel spectra
//
// Input words carry one channel's complex bin value plus bin and channel
// index; all channels of a bin arrive together, channel 0 first. A word is
// taken when in_valid is high and in_stall is low. Channels 0-1 add into bus
// A, channels 2-3 into bus B, and every word adds its power to a power sum.
// The word on the last channel (channel_count-1) closes the bin and yields
// one out word: root-sum-square power, complex sum A+B (split mode at or
// below split_bin), or A plus B rotated by the Q8.8 bus offset (delay mode).
// Words on channels at or above channel_count (clamped to 2..4) are dropped.
// Sequencing: in_stall is low only in the idle state. A non-closing word is
// accepted, then squared in two steps on the shared 18x16 multiplier. A
// closing word, after squaring, goes to the result state for the complex sum;
// delay mode adds phase, table, four rotation products and rounding (skipped
// at a zero phase index), and power runs the 17-step two-bit root and rounding.
// The out word sits in an output register; while out_stall is high it holds,
// and a further closing word waits in the result state until it drains.
// Configuration: cfg_ready is always high; write only while idle.
// Reset (rst_n low, synchronous) clears sums, out_valid, config (count to 4).
// ----------------------------------------------------------------------------
module multichannel_spectrum_combiner (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [msc_pkg::SMP_W-1:0]  in_sample_re,
  input  wire logic signed [msc_pkg::SMP_W-1:0]  in_sample_im,
  input  wire logic        [msc_pkg::BIN_W-1:0]  in_bin_index,
  input  wire logic        [msc_pkg::CH_W-1:0]   in_channel_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [msc_pkg::OUT_W-1:0]  out_re,
  output logic signed      [msc_pkg::OUT_W-1:0]  out_im,
  output logic             [msc_pkg::BIN_W-1:0]  out_bin,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic        [msc_pkg::CH_W-1:0]   cfg_index,
  input  wire logic        [msc_pkg::CFG_W-1:0]  cfg_data
);
  import msc_pkg::*;

  // configuration
  logic        [MODE_W-1:0] mode_r;
  logic        [BIN_W-1:0]  split_bin_r;
  logic signed [CFG_W-1:0]  offset_r;
  logic        [CNT_W-1:0]  count_r;

  // running sums
  logic signed [SUM_W-1:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic        [POW_W-1:0] power_r;

  // held sample and control
  state_t                   state_r, state_nxt;
  logic signed [SMP_W-1:0]  re_r, im_r;
  logic        [BIN_W-1:0]  bin_r;
  logic                     last_r;

  // shared multiplier and its accumulator
  logic signed [SUM_W-1:0]  mul_a;
  logic signed [SMP_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_r;

  // phase and table
  logic        [PHASE_BITS-1:0] idx_r;
  logic signed [SMP_W-1:0]      cos_r, sin_r;

  // root unit
  logic [POW_W-1:0]  rad_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [RCNT_W-1:0] rcnt_r;

  // pending result and output register
  logic signed [OUT_W-1:0] res_re_r, res_im_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_re_r, out_im_r;
  logic        [BIN_W-1:0] out_bin_r;

  // ---- channel count clamp and word qualification ----
  logic [CNT_W-1:0] n_eff;
  logic             ch_ok, ch_last, take;

  always_comb begin
    priority if (count_r < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (count_r > CNT_W'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = count_r;
    end
  end

  assign ch_ok   = CNT_W'(in_channel_index) < n_eff;
  assign ch_last = CNT_W'(in_channel_index) == (n_eff - CNT_W'(1));
  assign take    = in_valid && !in_stall;

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // ---- phase index from the registered offset*bin product ----
  logic                  acc_neg;
  logic [ACC_W-1:0]      acc_mag;
  logic [ACC_W-1:0]      idx_rnd;
  logic [PHASE_BITS-1:0] idx_pos, idx_calc;

  always_comb begin
    acc_neg  = acc_r[ACC_W-1];
    acc_mag  = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    idx_rnd  = (acc_mag + (ACC_W'(1) << (IDX_SHIFT - 1))) >> IDX_SHIFT;
    idx_pos  = idx_rnd[PHASE_BITS-1:0];
    idx_calc = acc_neg ? (PHASE_BITS'(0) - idx_pos) : idx_pos;
  end

  // ---- quarter-wave table, placed by quadrant ----
  logic [1:0]             quad;
  logic [QB-1:0]          frac;
  logic signed [SMP_W-1:0] st, ct, cos_nxt, sin_nxt;

  always_comb begin
    quad = idx_r[PHASE_BITS-1 -: 2];
    frac = idx_r[QB-1:0];
    st   = $signed(QSIN_TAB[frac]);
    ct   = (frac == '0) ? $signed(QSIN_ONE) : $signed(QSIN_TAB[QB'(0) - frac]);
    unique case (quad)
      2'd0: begin cos_nxt = ct;  sin_nxt = st;  end
      2'd1: begin cos_nxt = -st; sin_nxt = ct;  end
      2'd2: begin cos_nxt = -ct; sin_nxt = -st; end
      default: begin cos_nxt = st; sin_nxt = -ct; end
    endcase
  end

  // ---- root step: bring down two radicand bits, trial subtract ----
  logic [RSH_W-1:0] rem_sh, trial;
  logic             fits;

  always_comb begin
    rem_sh = {rem_r, rad_r[POW_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  // Q15 round half away from zero, then add to the bus A term
  function automatic logic signed [OUT_W-1:0] rot_out(
    input logic signed [ACC_W-1:0] v,
    input logic signed [SUM_W-1:0] base
  );
    logic [ACC_W-1:0]          mag;
    logic [ACC_W-1:0]          rm;
    logic signed [ACC_W-1:0]   sr;
    logic signed [ACC_W-1:0]   tot;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    rm  = (mag + (ACC_W'(1) << 14)) >> 15;
    sr  = v[ACC_W-1] ? -$signed(rm) : $signed(rm);
    tot = sr + ACC_W'(base);
    return tot[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] sum_re, sum_im;
  assign sum_re = OUT_W'(a_re_r) + OUT_W'(b_re_r);
  assign sum_im = OUT_W'(a_im_r) + OUT_W'(b_im_r);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && ch_ok) begin
          state_nxt = ST_SQ_RE;
        end
      end
      ST_SQ_RE: state_nxt = ST_SQ_IM;
      ST_SQ_IM: begin
        priority if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (mode_r == MODE_DELAY) begin
          state_nxt = ST_PHASE;
        end else if (mode_r == MODE_SPLIT && bin_r <= split_bin_r) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_ROOT;
        end
      end
      ST_PHASE:  state_nxt = ST_INDEX;
      ST_INDEX:  state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = (idx_r == '0) ? ST_RESULT : ST_ROT0;
      ST_ROT0:   state_nxt = ST_ROT1;
      ST_ROT1:   state_nxt = ST_ROT2;
      ST_ROT2:   state_nxt = ST_ROT3;
      ST_ROT3:   state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_RESULT;
      ST_ROOT: begin
        if (rcnt_r == '0) begin
          state_nxt = ST_ROOT_FIX;
        end
      end
      ST_ROOT_FIX: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- sequencer outputs: handshake and multiplier operands ----
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_SQ_RE: begin mul_a = SUM_W'(re_r); mul_b = re_r; end
      ST_SQ_IM: begin mul_a = SUM_W'(im_r); mul_b = im_r; end
      ST_PHASE: begin
        mul_a = $signed({{(SUM_W-BIN_W){1'b0}}, bin_r});
        mul_b = offset_r;
      end
      ST_ROT0: begin mul_a = b_re_r; mul_b = cos_r; end
      ST_ROT1: begin mul_a = b_im_r; mul_b = sin_r; end
      ST_ROT2: begin mul_a = b_re_r; mul_b = sin_r; end
      ST_ROT3: begin mul_a = b_im_r; mul_b = cos_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_POWER;
      split_bin_r <= '0;
      offset_r    <= '0;
      count_r     <= CNT_W'(MAX_CHANNELS);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE:   mode_r      <= cfg_data[MODE_W-1:0];
          REG_SPLIT:  split_bin_r <= cfg_data[BIN_W-1:0];
          REG_OFFSET: offset_r    <= $signed(cfg_data);
          REG_COUNT:  count_r     <= cfg_data[CNT_W-1:0];
          default:    mode_r      <= mode_r;
        endcase
      end
      // drop the out word once taken, raise it when a result lands
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- sums: cleared by reset and after each closed bin ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_re_r  <= '0;
      a_im_r  <= '0;
      b_re_r  <= '0;
      b_im_r  <= '0;
      power_r <= '0;
    end else if (state_r == ST_RESULT && out_free) begin
      a_re_r  <= '0;
      a_im_r  <= '0;
      b_re_r  <= '0;
      b_im_r  <= '0;
      power_r <= '0;
    end else if (state_r == ST_IDLE && take && ch_ok) begin
      if (!in_channel_index[CH_W-1]) begin
        a_re_r <= a_re_r + SUM_W'(in_sample_re);
        a_im_r <= a_im_r + SUM_W'(in_sample_im);
      end else begin
        b_re_r <= b_re_r + SUM_W'(in_sample_re);
        b_im_r <= b_im_r + SUM_W'(in_sample_im);
      end
    end else if (state_r == ST_SQ_RE || state_r == ST_SQ_IM) begin
      power_r <= power_r + POW_W'(prod);
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && take) begin
      re_r   <= in_sample_re;
      im_r   <= in_sample_im;
      bin_r  <= in_bin_index;
      last_r <= ch_last;
    end
    if (state_r == ST_SQ_IM) begin
      rad_r  <= power_r + POW_W'(prod);
      root_r <= '0;
      rem_r  <= '0;
      rcnt_r <= RCNT_W'(ROOT_STEPS - 1);
      res_re_r <= sum_re;
      res_im_r <= sum_im;
    end
    unique case (state_r)
      ST_PHASE:  acc_r <= ACC_W'(prod);
      ST_INDEX:  idx_r <= idx_calc;
      ST_LOOKUP: begin
        cos_r    <= cos_nxt;
        sin_r    <= sin_nxt;
        res_re_r <= sum_re;
        res_im_r <= sum_im;
      end
      ST_ROT0: acc_r <= ACC_W'(prod);
      ST_ROT1: acc_r <= acc_r - ACC_W'(prod);
      ST_ROT2: begin
        res_re_r <= rot_out(acc_r, a_re_r);
        acc_r    <= ACC_W'(prod);
      end
      ST_ROT3:  acc_r <= acc_r + ACC_W'(prod);
      ST_ROUND: res_im_r <= rot_out(acc_r, a_im_r);
      ST_ROOT: begin
        rad_r  <= rad_r << 2;
        rcnt_r <= rcnt_r - RCNT_W'(1);
        if (fits) begin
          rem_r  <= REM_W'(rem_sh - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= REM_W'(rem_sh);
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      ST_ROOT_FIX: begin
        // round to nearest: step up when the remainder exceeds the root
        res_re_r <= OUT_W'(root_r) + OUT_W'(REM_W'(rem_r) > REM_W'(root_r));
        res_im_r <= '0;
      end
      default: acc_r <= acc_r;
    endcase
    if (state_r == ST_RESULT && out_free) begin
      out_re_r  <= res_re_r;
      out_im_r  <= res_im_r;
      out_bin_r <= bin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;
  assign out_bin   = out_bin_r;

endmodule
`default_nettype wire
